[sv/lfmr_pkg.sv]
// ============================================================================
// lfmr_pkg
// Shared constants, types and state encoding for the largest finite
// Manhattan region block.
// ============================================================================
package lfmr_pkg;

    localparam int MAX_SITES  = 64;
    localparam int COORD_BITS = 10;
    localparam int AREA_W     = 21;
    localparam int IDX_W      = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CNT_W      = $clog2(MAX_SITES + 1);
    localparam int DIST_W     = COORD_BITS + 1;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_FIN,
        ST_FIN_DRAIN,
        ST_OUT
    } t_state;

    // one site sample offered to the nearest-site unit
    typedef struct packed {
        logic                  v;
        logic                  first;
        logic                  last;
        logic [IDX_W-1:0]      idx;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
    } t_near_req;

    // verdict for the current grid point
    typedef struct packed {
        logic             done;
        logic             unique_owner;
        logic [IDX_W-1:0] owner;
    } t_near_res;

endpackage

[sv/lfmr_in_if.sv]
// ============================================================================
// lfmr_in_if
// Input channel: site loads and compute requests.
// ============================================================================
interface lfmr_in_if
    import lfmr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] site_x;
    logic [COORD_BITS-1:0] site_y;

    modport source (output valid, op, site_x, site_y, input ready);
    modport sink   (input valid, op, site_x, site_y, output ready);
endinterface

[sv/lfmr_out_if.sv]
// ============================================================================
// lfmr_out_if
// Output channel: one result per compute request.
// ============================================================================
interface lfmr_out_if
    import lfmr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [AREA_W-1:0] largest_area;
    logic              found;

    modport source (output valid, largest_area, found, input ready);
    modport sink   (input valid, largest_area, found, output ready);
endinterface

[sv/lfmr_site_mem.sv]
// ============================================================================
// lfmr_site_mem
// Site coordinate store, one write and one registered read per cycle.
// ============================================================================
module lfmr_site_mem
    import lfmr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  logic [COORD_BITS-1:0] i_wr_x,
    input  logic [COORD_BITS-1:0] i_wr_y,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output logic [COORD_BITS-1:0] o_rd_x,
    output logic [COORD_BITS-1:0] o_rd_y
);

    logic [2*COORD_BITS-1:0] r_mem [MAX_SITES];
    logic [2*COORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_x = r_rd_data[2*COORD_BITS-1:COORD_BITS];
    assign o_rd_y = r_rd_data[COORD_BITS-1:0];

endmodule

[sv/lfmr_area_mem.sv]
// ============================================================================
// lfmr_area_mem
// Per-site area counters with valid bits and border flags.
// ============================================================================
module lfmr_area_mem
    import lfmr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic [AREA_W-1:0] o_rd_area,
    output logic              o_rd_edge,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [AREA_W-1:0] i_wr_area,
    input  logic              i_wr_edge
);

    logic [AREA_W-1:0]    r_mem [MAX_SITES];
    logic [MAX_SITES-1:0] r_valid;
    logic [MAX_SITES-1:0] r_edge;
    logic [AREA_W-1:0]    r_rd_data;
    logic                 r_rd_valid;
    logic                 r_rd_edge;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_area;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid    <= '0;
            r_edge     <= '0;
            r_rd_valid <= 1'b0;
            r_rd_edge  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
                if (i_wr_edge) begin
                    r_edge[i_wr_addr] <= 1'b1;
                end
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                r_rd_edge  <= r_edge[i_rd_addr];
            end
        end
    end

    // an entry never written since the clear counts as zero
    assign o_rd_area = r_rd_valid ? r_rd_data : '0;
    assign o_rd_edge = r_rd_edge;

endmodule

[sv/lfmr_near_unit.sv]
// ============================================================================
// lfmr_near_unit
// Shared distance and compare unit: one site per cycle, tracks the
// nearest site and ties for the current grid point.
// ============================================================================
module lfmr_near_unit
    import lfmr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    input  t_near_req             i_req,
    output t_near_res             o_res
);

    logic [COORD_BITS-1:0] s_dx;
    logic [COORD_BITS-1:0] s_dy;
    logic [DIST_W-1:0]     s_dist;

    logic [DIST_W-1:0]     r_dist;
    logic                  r_v;
    logic                  r_first;
    logic                  r_last;
    logic [IDX_W-1:0]      r_idx;

    logic [DIST_W-1:0]     r_best;
    logic [IDX_W-1:0]      r_owner;
    logic                  r_tie;
    logic                  r_done;

    always_comb begin
        s_dx   = (i_px >= i_req.sx) ? (i_px - i_req.sx) : (i_req.sx - i_px);
        s_dy   = (i_py >= i_req.sy) ? (i_py - i_req.sy) : (i_req.sy - i_py);
        s_dist = {1'b0, s_dx} + {1'b0, s_dy};
    end

    // stage 1: distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_req.v;
        end
        r_dist  <= s_dist;
        r_first <= i_req.first;
        r_last  <= i_req.last;
        r_idx   <= i_req.idx;
    end

    // stage 2: running minimum with tie tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_tie  <= 1'b0;
        end else begin
            r_done <= r_v && r_last;
            if (r_v) begin
                priority if (r_first || (r_dist < r_best)) begin
                    r_best  <= r_dist;
                    r_owner <= r_idx;
                    r_tie   <= 1'b0;
                end else if (r_dist == r_best) begin
                    r_tie <= 1'b1;
                end
            end
        end
    end

    assign o_res.done         = r_done;
    assign o_res.unique_owner = !r_tie;
    assign o_res.owner        = r_owner;

endmodule

[sv/largest_finite_manhattan_region_top.sv]
// ============================================================================
// largest_finite_manhattan_region_top
// Collects sites, partitions their bounding box by nearest Manhattan site
// and reports the largest region that does not touch the box border.
// ============================================================================
//
//  Port    Dir   Transaction                          Fields
//  ------  ----  -----------------------------------  -------------------------
//  i_in    sink  op 0: load site, op 1: run sweep     op, site_x, site_y
//  o_out   src   one per sweep                        largest_area, found
//
//  Loads may come back to back. A full table drops a load.
//  With sites loaded, the sweep visits each point of the bounding box in
//  turn: the shared distance/compare unit sees one site per cycle while a
//  point is scanned, and the point's unique owner, if any, gets its area
//  counted; a final pass over the sites follows. An empty table
//  offers its result on the cycle after the sweep transaction.
//  i_in.ready is low from the sweep request until its result is taken.
//  Synchronous reset empties the table; no memory clearing pass.
//  o_out holds its result until the sink takes it.
//
module largest_finite_manhattan_region_top
    import lfmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfmr_in_if.sink     i_in,
    lfmr_out_if.source  o_out
);

    localparam logic [CNT_W-1:0]      TOTAL_FULL = CNT_W'(MAX_SITES);
    localparam logic [COORD_BITS-1:0] COORD_ONES = '1;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [CNT_W-1:0]      r_total,  n_total;
    logic [COORD_BITS-1:0] r_min_x,  n_min_x;
    logic [COORD_BITS-1:0] r_max_x,  n_max_x;
    logic [COORD_BITS-1:0] r_min_y,  n_min_y;
    logic [COORD_BITS-1:0] r_max_y,  n_max_y;
    logic [COORD_BITS-1:0] r_px,     n_px;
    logic [COORD_BITS-1:0] r_py,     n_py;
    logic [IDX_W-1:0]      r_idx,    n_idx;
    logic [AREA_W-1:0]     r_largest, n_largest;
    logic                  r_found,  n_found;

    // read-pipeline tags, aligned with registered memory data
    logic                  r_s1_v, r_s1_first, r_s1_last;
    logic [IDX_W-1:0]      r_s1_idx;
    logic                  r_f_v, r_f_last;

    // ------------------------------------------------------------------
    // Control strobes
    // ------------------------------------------------------------------
    logic s_in_acc;
    logic s_out_acc;
    logic s_load;
    logic s_compute;
    logic s_idx_last;
    logic s_pt_last;
    logic s_border;
    logic s_site_rd;
    logic s_area_rd;
    logic s_area_wr;
    logic s_area_clr;
    logic [IDX_W-1:0] s_area_addr;

    logic [COORD_BITS-1:0] s_site_x, s_site_y;
    logic [AREA_W-1:0]     s_area_rd_data;
    logic                  s_area_rd_edge;
    t_near_req             s_near_req;
    t_near_res             s_near_res;

    assign s_in_acc   = i_in.valid && i_in.ready;
    assign s_out_acc  = o_out.valid && o_out.ready;
    assign s_load     = s_in_acc && (t_op'(i_in.op) == OP_LOAD);
    assign s_compute  = s_in_acc && (t_op'(i_in.op) == OP_COMPUTE);
    assign s_idx_last = ({1'b0, r_idx} == (r_total - CNT_W'(1)));
    assign s_pt_last  = (r_px == r_max_x) && (r_py == r_max_y);
    assign s_border   = (r_px == r_min_x) || (r_px == r_max_x) ||
                        (r_py == r_min_y) || (r_py == r_max_y);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_compute) begin
                    n_state = (r_total == '0) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (s_idx_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (s_near_res.done) begin
                    priority if (s_near_res.unique_owner) begin
                        n_state = ST_UPD_RD;
                    end else if (s_pt_last) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_UPD_RD: begin
                n_state = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                n_state = s_pt_last ? ST_FIN : ST_SCAN;
            end
            ST_FIN: begin
                if (s_idx_last) begin
                    n_state = ST_FIN_DRAIN;
                end
            end
            ST_FIN_DRAIN: begin
                if (r_f_v && r_f_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (s_out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs / strobes per state
    // ------------------------------------------------------------------
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        s_site_rd   = 1'b0;
        s_area_rd   = 1'b0;
        s_area_wr   = 1'b0;
        s_area_addr = r_idx;
        unique case (r_state)
            ST_IDLE:      i_in.ready  = 1'b1;
            ST_SCAN:      s_site_rd   = 1'b1;
            ST_DRAIN:     ;
            ST_UPD_RD: begin
                s_area_rd   = 1'b1;
                s_area_addr = s_near_res.owner;
            end
            ST_UPD_WR: begin
                s_area_wr   = 1'b1;
                s_area_addr = s_near_res.owner;
            end
            ST_FIN:       s_area_rd   = 1'b1;
            ST_FIN_DRAIN: ;
            ST_OUT:       o_out.valid = 1'b1;
            default:      ;
        endcase
    end

    assign s_area_clr         = s_compute;
    assign o_out.largest_area = r_largest;
    assign o_out.found        = r_found;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_total   = r_total;
        n_min_x   = r_min_x;
        n_max_x   = r_max_x;
        n_min_y   = r_min_y;
        n_max_y   = r_max_y;
        n_px      = r_px;
        n_py      = r_py;
        n_idx     = r_idx;
        n_largest = r_largest;
        n_found   = r_found;

        // site load: drop it when the table is full
        if (s_load && (r_total != TOTAL_FULL)) begin
            n_total = r_total + CNT_W'(1);
            if (i_in.site_x < r_min_x) n_min_x = i_in.site_x;
            if (i_in.site_x > r_max_x) n_max_x = i_in.site_x;
            if (i_in.site_y < r_min_y) n_min_y = i_in.site_y;
            if (i_in.site_y > r_max_y) n_max_y = i_in.site_y;
        end

        if (s_compute) begin
            n_px      = r_min_x;
            n_py      = r_min_y;
            n_idx     = '0;
            n_largest = '0;
            n_found   = 1'b0;
        end

        // site index walk for the scan and the final pass
        if ((r_state == ST_SCAN) || (r_state == ST_FIN)) begin
            n_idx = s_idx_last ? '0 : (r_idx + IDX_W'(1));
        end

        // step to the next grid point, column-major as in the sweep order
        if (((r_state == ST_DRAIN) && s_near_res.done && !s_near_res.unique_owner) ||
            (r_state == ST_UPD_WR)) begin
            if (!s_pt_last) begin
                if (r_py == r_max_y) begin
                    n_py = r_min_y;
                    n_px = r_px + COORD_BITS'(1);
                end else begin
                    n_py = r_py + COORD_BITS'(1);
                end
            end
        end

        // final pass: largest area among sites never seen on the border
        if (r_f_v && !s_area_rd_edge) begin
            if (!r_found || (s_area_rd_data > r_largest)) begin
                n_largest = s_area_rd_data;
            end
            n_found = 1'b1;
        end

        // result taken: empty the table and the box
        if (s_out_acc) begin
            n_total = '0;
            n_min_x = COORD_ONES;
            n_max_x = '0;
            n_min_y = COORD_ONES;
            n_max_y = '0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_total  <= '0;
            r_min_x  <= COORD_ONES;
            r_max_x  <= '0;
            r_min_y  <= COORD_ONES;
            r_max_y  <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_s1_v   <= 1'b0;
            r_f_v    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_min_x  <= n_min_x;
            r_max_x  <= n_max_x;
            r_min_y  <= n_min_y;
            r_max_y  <= n_max_y;
            r_idx    <= n_idx;
            r_found  <= n_found;
            r_s1_v   <= s_site_rd;
            r_f_v    <= (r_state == ST_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_px       <= n_px;
        r_py       <= n_py;
        r_largest  <= n_largest;
        r_s1_first <= (r_idx == '0);
        r_s1_last  <= s_idx_last;
        r_s1_idx   <= r_idx;
        r_f_last   <= s_idx_last;
    end

    // ------------------------------------------------------------------
    // Storage and the shared nearest-site unit
    // ------------------------------------------------------------------
    lfmr_site_mem u_site_mem (
        .i_clk     (i_clk),
        .i_wr_en   (s_load && (r_total != TOTAL_FULL)),
        .i_wr_addr (r_total[IDX_W-1:0]),
        .i_wr_x    (i_in.site_x),
        .i_wr_y    (i_in.site_y),
        .i_rd_en   (s_site_rd),
        .i_rd_addr (r_idx),
        .o_rd_x    (s_site_x),
        .o_rd_y    (s_site_y)
    );

    assign s_near_req.v     = r_s1_v;
    assign s_near_req.first = r_s1_first;
    assign s_near_req.last  = r_s1_last;
    assign s_near_req.idx   = r_s1_idx;
    assign s_near_req.sx    = s_site_x;
    assign s_near_req.sy    = s_site_y;

    lfmr_near_unit u_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_req   (s_near_req),
        .o_res   (s_near_res)
    );

    lfmr_area_mem u_area_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (s_area_clr),
        .i_rd_en   (s_area_rd),
        .i_rd_addr (s_area_addr),
        .o_rd_area (s_area_rd_data),
        .o_rd_edge (s_area_rd_edge),
        .i_wr_en   (s_area_wr),
        .i_wr_addr (s_area_addr),
        .i_wr_area (s_area_rd_data + AREA_W'(1)),
        .i_wr_edge (s_border)
    );

endmodule

[sv/lfmr_checker.sv]
// ============================================================================
// lfmr_checker
// Port-level checks for the largest finite Manhattan region block.
// ============================================================================
module lfmr_checker
    import lfmr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [AREA_W-1:0] i_out_largest_area,
    input logic              i_out_found
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_largest_area) && $stable(i_out_found)))
        else $error("result dropped or changed while stalled");

    // no new transaction is taken while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while result pending");

    // no finite site means a zero area
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_found) |-> (i_out_largest_area == '0))
        else $error("nonzero area without a finite site");

    // once the result is taken the block is ready again
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> (i_in_ready && !i_out_valid))
        else $error("not ready after result transaction");

endmodule

bind largest_finite_manhattan_region_top lfmr_checker u_lfmr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_largest_area (o_out.largest_area),
    .i_out_found        (o_out.found)
);
